// ----- hdl/imu_rx_pkg.sv -----
// Shared constants and types for the serial IMU frame receiver.
package imu_rx_pkg;

	localparam int FRAME_LEN  = 33;
	localparam int PACKET_LEN = 11;
	localparam int SUM_LEN    = 10;
	localparam int BANKS      = 2;
	localparam int MEM_DEPTH  = BANKS * FRAME_LEN;
	localparam int IDX_W      = $clog2(FRAME_LEN);
	localparam int PKT_W      = $clog2(PACKET_LEN);
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int COUNT_W    = 32;

	localparam logic [7:0]        HEADER_BYTE = 8'h55;
	localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(FRAME_LEN - 1);
	localparam logic [PKT_W-1:0]  SUM_POS     = PKT_W'(SUM_LEN);
	localparam logic [ADDR_W-1:0] BANK_BASE   = ADDR_W'(FRAME_LEN);

	// One write into the frame buffer.
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

	// One finished frame, handed from the front to the back.
	typedef struct packed {
		logic               bank;
		logic               ok;
		logic [COUNT_W-1:0] count;
	} frame_desc_t;

endpackage

// ----- hdl/imu_rx_front.sv -----
// Front end: header hunting, frame collection and on-the-fly header and sum checks.
module imu_rx_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [7:0]             byte_in,
	output imu_rx_pkg::mem_wr_t    wr,
	output logic                   desc_push,
	output imu_rx_pkg::frame_desc_t desc
);

	logic [imu_rx_pkg::IDX_W-1:0]   pos_q;
	logic [imu_rx_pkg::PKT_W-1:0]   pkt_q;
	logic [7:0]                     sum_q;
	logic                           ok_q;
	logic                           bank_q;
	logic [imu_rx_pkg::COUNT_W-1:0] good_q;

	logic       active;
	logic       hdr_bad;
	logic       sum_bad;
	logic       ok_n;
	logic       frame_end;

	assign active    = accept && ((pos_q != '0) || (byte_in == imu_rx_pkg::HEADER_BYTE));
	assign hdr_bad   = (pkt_q == '0) && (byte_in != imu_rx_pkg::HEADER_BYTE);
	assign sum_bad   = (pkt_q == imu_rx_pkg::SUM_POS) && (byte_in != sum_q);
	assign ok_n      = ok_q && !hdr_bad && !sum_bad;
	assign frame_end = active && (pos_q == imu_rx_pkg::LAST_IDX);

	always_comb begin
		wr.en   = active;
		wr.data = byte_in;
		wr.addr = bank_q ? imu_rx_pkg::BANK_BASE + imu_rx_pkg::ADDR_W'(pos_q)
		                 : imu_rx_pkg::ADDR_W'(pos_q);
	end

	assign desc_push  = frame_end;
	assign desc.bank  = bank_q;
	assign desc.ok    = ok_n;
	assign desc.count = ok_n ? good_q + 1'b1 : good_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			pkt_q  <= '0;
			ok_q   <= 1'b1;
			bank_q <= 1'b0;
			good_q <= '0;
		end else if (active) begin
			if (frame_end) begin
				pos_q  <= '0;
				pkt_q  <= '0;
				ok_q   <= 1'b1;
				bank_q <= !bank_q;
				good_q <= desc.count;
			end else begin
				pos_q <= pos_q + 1'b1;
				pkt_q <= (pkt_q == imu_rx_pkg::SUM_POS) ? '0 : pkt_q + 1'b1;
				ok_q  <= ok_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active) begin
			sum_q <= (pkt_q == '0) ? byte_in : sum_q + byte_in;
		end
	end

endmodule

// ----- hdl/imu_rx_queue.sv -----
// Two-entry queue of finished-frame descriptors between the front and the back.
module imu_rx_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  imu_rx_pkg::frame_desc_t wr_desc,
	input  logic                    rd_en,
	output imu_rx_pkg::frame_desc_t head,
	output logic                    q_full,
	output logic                    q_empty
);

	imu_rx_pkg::frame_desc_t entry_q [imu_rx_pkg::BANKS];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign head    = entry_q[rd_ptr_q];
	assign q_full  = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_desc;
		end
	end

endmodule

// ----- hdl/imu_rx_back.sv -----
// Back end: frame buffer memory and the readout of results, one per cycle while pop keeps taking them.
module imu_rx_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  imu_rx_pkg::mem_wr_t            wr,
	input  logic                           q_empty,
	input  imu_rx_pkg::frame_desc_t        head,
	output logic                           q_pop,
	input  logic                           pop,
	output logic                           empty,
	output logic [7:0]                     byte_value,
	output logic [imu_rx_pkg::IDX_W-1:0]   byte_index,
	output logic                           frame_ok,
	output logic                           last,
	output logic [imu_rx_pkg::COUNT_W-1:0] frame_count
);

	logic [7:0] frame_mem_q [imu_rx_pkg::MEM_DEPTH];

	logic [imu_rx_pkg::IDX_W-1:0]   idx_q;

	// Read stage: request issued, memory data arrives in rd_s1.
	logic                           vld_s1;
	logic [7:0]                     rd_s1;
	logic [imu_rx_pkg::IDX_W-1:0]   idx_s1;
	logic                           ok_s1;
	logic                           last_s1;
	logic [imu_rx_pkg::COUNT_W-1:0] cnt_s1;

	// Output register.
	logic                           vld_s2;
	logic [7:0]                     val_s2;
	logic [imu_rx_pkg::IDX_W-1:0]   idx_s2;
	logic                           ok_s2;
	logic                           last_s2;
	logic [imu_rx_pkg::COUNT_W-1:0] cnt_s2;

	logic                          move_s2;
	logic                          issue;
	logic                          issue_last;
	logic [imu_rx_pkg::ADDR_W-1:0] rd_addr;

	assign move_s2    = vld_s1 && (!vld_s2 || pop);
	assign issue      = !q_empty && (!vld_s1 || move_s2);
	assign issue_last = !head.ok || (idx_q == imu_rx_pkg::LAST_IDX);
	assign q_pop      = issue && issue_last;
	assign rd_addr    = head.bank ? imu_rx_pkg::BANK_BASE + imu_rx_pkg::ADDR_W'(idx_q)
	                              : imu_rx_pkg::ADDR_W'(idx_q);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			frame_mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_s1   <= frame_mem_q[rd_addr];
			idx_s1  <= head.ok ? idx_q : '0;
			ok_s1   <= head.ok;
			last_s1 <= issue_last;
			cnt_s1  <= head.count;
		end
		if (move_s2) begin
			val_s2  <= ok_s1 ? rd_s1 : 8'h00;
			idx_s2  <= idx_s1;
			ok_s2   <= ok_s1;
			last_s2 <= last_s1;
			cnt_s2  <= cnt_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (issue) begin
				idx_q <= issue_last ? '0 : idx_q + 1'b1;
			end
			if (issue) begin
				vld_s1 <= 1'b1;
			end else if (move_s2) begin
				vld_s1 <= 1'b0;
			end
			if (move_s2) begin
				vld_s2 <= 1'b1;
			end else if (pop) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	assign empty       = !vld_s2;
	assign byte_value  = val_s2;
	assign byte_index  = idx_s2;
	assign frame_ok    = ok_s2;
	assign last        = last_s2;
	assign frame_count = cnt_s2;

endmodule

// ----- hdl/imu_frame_receiver.sv -----
// Top level of the serial IMU frame receiver.
//
// The receiver takes one serial byte per word on its input queue port and
// hunts for a 0x55 header, dropping every other byte until one arrives. It
// then collects a 33-byte frame of three 11-byte packets, checking on the fly
// that bytes 0, 11 and 22 are headers and that each packet's last byte equals
// the low eight bits of the sum of its first ten bytes. A good frame bumps
// the 32-bit wrapping frame counter and is read out as 33 words, each carrying
// the byte, its index, frame_ok high, the count including this frame, and last
// on index 32. A bad frame yields one word with zero byte and index, frame_ok
// low, last high and the unchanged count. The input side takes one byte per
// cycle while full is low. Readout of a good frame gives one word per cycle
// while pop keeps taking them, set by the single read port of the frame buffer.
// The buffer holds two frames, so the input side stalls (full high) only while
// two finished frames are still waiting for readout.
module imu_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  byte_in,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  byte_value,
	output logic [5:0]  byte_index,
	output logic        frame_ok,
	output logic        last,
	output logic [31:0] frame_count
);

	imu_rx_pkg::mem_wr_t     wr;
	imu_rx_pkg::frame_desc_t desc;
	imu_rx_pkg::frame_desc_t head;
	logic                    desc_push;
	logic                    q_pop;
	logic                    q_full;
	logic                    q_empty;
	logic                    accept;

	// A byte is taken whenever a free frame buffer bank is guaranteed.
	assign full   = q_full;
	assign accept = push && !q_full;

	imu_rx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.byte_in   (byte_in),
		.wr        (wr),
		.desc_push (desc_push),
		.desc      (desc)
	);

	imu_rx_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (desc_push),
		.wr_desc (desc),
		.rd_en   (q_pop),
		.head    (head),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	imu_rx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (wr),
		.q_empty     (q_empty),
		.head        (head),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.byte_value  (byte_value),
		.byte_index  (byte_index),
		.frame_ok    (frame_ok),
		.last        (last),
		.frame_count (frame_count)
	);

endmodule

// ----- verif/imu_frame_receiver_checker.sv -----
// Checker for the IMU frame receiver: predicts result words from accepted bytes and compares them.
module imu_frame_receiver_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  byte_in,
	input  logic        empty,
	input  logic        pop,
	input  logic [7:0]  byte_value,
	input  logic [5:0]  byte_index,
	input  logic        frame_ok,
	input  logic        last,
	input  logic [31:0] frame_count,
	output int unsigned fail_count,
	output int unsigned words_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]  value;
		logic [5:0]  index;
		logic        ok;
		logic        last;
		logic [31:0] count;
	} rx_word_t;

	rx_word_t    owed_q[$];
	logic [7:0]  held_bytes [imu_rx_pkg::FRAME_LEN];
	int unsigned fill_pos;
	logic [31:0] frames_passed;
	int unsigned mism;

	initial begin
		fail_count = 0;
		words_owed = 0;
		mism = 0;
	end

	// Compare first, then predict: a word is never due on the edge that accepts the byte
	// which completes its frame.
	always @(posedge clk or negedge arst_n) begin : track
		rx_word_t   w;
		logic       frame_good;
		logic [7:0] csum;
		if (!arst_n) begin
			fill_pos = 0;
			frames_passed = '0;
			owed_q.delete();
		end else begin
			if (pop && !empty) begin
				if (owed_q.size() == 0) begin
					$error("unexpected word: byte_value %0h byte_index %0d frame_ok %0b",
						byte_value, byte_index, frame_ok);
					mism++;
				end else begin
					w = owed_q.pop_front();
					if (byte_value !== w.value) begin
						$error("byte_value: expected %0h, got %0h", w.value, byte_value);
						mism++;
					end
					if (byte_index !== w.index) begin
						$error("byte_index: expected %0d, got %0d", w.index, byte_index);
						mism++;
					end
					if (frame_ok !== w.ok) begin
						$error("frame_ok: expected %0b, got %0b", w.ok, frame_ok);
						mism++;
					end
					if (last !== w.last) begin
						$error("last: expected %0b, got %0b", w.last, last);
						mism++;
					end
					if (frame_count !== w.count) begin
						$error("frame_count: expected %0d, got %0d", w.count, frame_count);
						mism++;
					end
				end
			end

			// Bytes other than a header are dropped while hunting.
			if (push && !full &&
				(fill_pos != 0 || byte_in == imu_rx_pkg::HEADER_BYTE)) begin
				held_bytes[fill_pos] = byte_in;
				fill_pos++;
				if (fill_pos == imu_rx_pkg::FRAME_LEN) begin
					fill_pos = 0;
					frame_good = 1'b1;
					for (int p = 0; p < 3; p++) begin
						csum = '0;
						for (int i = 0; i < imu_rx_pkg::SUM_LEN; i++)
							csum += held_bytes[p*imu_rx_pkg::PACKET_LEN + i];
						if (held_bytes[p*imu_rx_pkg::PACKET_LEN] != imu_rx_pkg::HEADER_BYTE ||
							held_bytes[p*imu_rx_pkg::PACKET_LEN + imu_rx_pkg::SUM_LEN] != csum)
							frame_good = 1'b0;
					end
					if (frame_good) begin
						frames_passed++;
						for (int k = 0; k < imu_rx_pkg::FRAME_LEN; k++) begin
							w.value = held_bytes[k];
							w.index = 6'(k);
							w.ok    = 1'b1;
							w.last  = (k == imu_rx_pkg::FRAME_LEN - 1);
							w.count = frames_passed;
							owed_q.push_back(w);
						end
					end else begin
						w = '{value: '0, index: '0, ok: 1'b0, last: 1'b1, count: frames_passed};
						owed_q.push_back(w);
					end
				end
			end
		end
		fail_count <= mism;
		words_owed <= owed_q.size();
	end

endmodule

// ----- verif/imu_frame_receiver_tb.sv -----
// Testbench top for the IMU frame receiver: byte stimulus, result draining and the verdict.
module imu_frame_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Bytes of random frames to send after the directed part and the back-pressure burst.
	localparam int RANDOM_BYTES = 100;
	// Stretch during which the result side refuses every word, long enough for the
	// input side to fill both frame banks and raise full.
	localparam int HOLD_CYCLES  = 600;
	// Settling time after the last expected word, well beyond one frame readout.
	localparam int DRAIN_CYCLES = 80;
	// Worst case is roughly 350 bytes and 350 words each waiting out the longest gap,
	// plus the hold; this is several times that.
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum int {CONTENT_RANDOM, CONTENT_ONES, CONTENT_ZEROS} payload_t;
	typedef enum int {FLAW_NONE, FLAW_HEADER_B, FLAW_HEADER_C, FLAW_SUM} flaw_t;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        push    = 1'b0;
	logic [7:0]  byte_in = '0;
	logic        pop     = 1'b0;
	logic        full;
	logic        empty;
	logic [7:0]  byte_value;
	logic [5:0]  byte_index;
	logic        frame_ok;
	logic        last;
	logic [31:0] frame_count;

	int unsigned fail_count;
	int unsigned words_owed;

	logic [7:0] tx_q[$];        // bytes waiting to be offered to the receiver
	bit         tx_burst = 1'b0; // when set, the sender offers bytes back to back
	bit         hold_req = 1'b0; // asks the result side for its one long hold-off
	int         cycle_count = 0;

	always #1 clk = ~clk;

	imu_frame_receiver u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.byte_in    (byte_in),
		.empty      (empty),
		.pop        (pop),
		.byte_value (byte_value),
		.byte_index (byte_index),
		.frame_ok   (frame_ok),
		.last       (last),
		.frame_count(frame_count)
	);

	imu_frame_receiver_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.byte_in    (byte_in),
		.empty      (empty),
		.pop        (pop),
		.byte_value (byte_value),
		.byte_index (byte_index),
		.frame_ok   (frame_ok),
		.last       (last),
		.frame_count(frame_count),
		.fail_count (fail_count),
		.words_owed (words_owed)
	);

	// Idle gap length: mostly none or a few cycles, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Appends one 33-byte frame: three packets, each a header, nine payload bytes and
	// the low byte of the sum of the first ten. A flaw breaks one header or one sum.
	function automatic void queue_frame(input payload_t content, input flaw_t flaw);
		logic [7:0] pkt [imu_rx_pkg::PACKET_LEN];
		logic [7:0] csum;
		int         bad_pkt;
		bad_pkt = $urandom_range(0, 2);
		for (int p = 0; p < 3; p++) begin
			pkt[0] = imu_rx_pkg::HEADER_BYTE;
			for (int i = 1; i < imu_rx_pkg::SUM_LEN; i++) begin
				case (content)
					CONTENT_ONES:  pkt[i] = 8'hFF;
					CONTENT_ZEROS: pkt[i] = 8'h00;
					default:       pkt[i] = 8'($urandom);
				endcase
			end
			csum = '0;
			for (int i = 0; i < imu_rx_pkg::SUM_LEN; i++)
				csum += pkt[i];
			pkt[imu_rx_pkg::SUM_LEN] = csum;
			// A corrupted header is any value but the header itself.
			if ((flaw == FLAW_HEADER_B && p == 1) || (flaw == FLAW_HEADER_C && p == 2)) begin
				do
					pkt[0] = 8'($urandom);
				while (pkt[0] == imu_rx_pkg::HEADER_BYTE);
			end
			if (flaw == FLAW_SUM && p == bad_pkt)
				pkt[imu_rx_pkg::SUM_LEN] ^= 8'($urandom_range(1, 255));
			for (int i = 0; i < imu_rx_pkg::PACKET_LEN; i++)
				tx_q.push_back(pkt[i]);
		end
	endfunction

	// Line noise that can never start a frame.
	function automatic void queue_noise(input int n);
		logic [7:0] b;
		repeat (n) begin
			do
				b = 8'($urandom);
			while (b == imu_rx_pkg::HEADER_BYTE);
			tx_q.push_back(b);
		end
	endfunction

	// Offers every queued byte in turn. push stays high while full is set, so each
	// byte waits for the handshake; a zero gap keeps push high across bytes.
	task automatic send_queued();
		int gap;
		while (tx_q.size() != 0) begin
			gap = tx_burst ? 0 : pick_gap();
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			push    <= 1'b1;
			byte_in <= tx_q.pop_front();
			do
				@(posedge clk);
			while (full);
		end
	endtask

	// Result side. It stalls at random, switches now and then into a steady stretch
	// with pop held high, and once, when asked, refuses every word for a long stretch
	// so that the frame banks fill and the input side is held off.
	initial begin : result_sink
		int gap;
		bit held;
		bit steady;
		held   = 1'b0;
		steady = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if ($urandom_range(0, 24) == 0)
				steady = !steady;
			gap = steady ? 0 : pick_gap();
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do
				@(posedge clk);
			while (empty);
		end
	end

	initial begin : stimulus
		int scored;
		int pick;
		int cut;
		scored = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: noise while hunting (including the neighbors of the header
		// value and both extremes), a good frame with an all-ones payload so that the
		// sums wrap, a frame whose second header is broken with an all-zero payload,
		// and a frame with one bad sum.
		tx_q.push_back(8'h00);
		tx_q.push_back(8'hFF);
		tx_q.push_back(8'h54);
		tx_q.push_back(8'h56);
		queue_frame(CONTENT_ONES, FLAW_NONE);
		queue_frame(CONTENT_ZEROS, FLAW_HEADER_B);
		queue_frame(CONTENT_RANDOM, FLAW_SUM);
		send_queued();

		// Back-pressure burst: good frames back to back while the result side holds
		// off, so both banks fill and full must stall the input.
		hold_req = 1'b1;
		tx_burst = 1'b1;
		repeat (4) queue_frame(CONTENT_RANDOM, FLAW_NONE);
		send_queued();

		// Random part: mostly good frames with random content; the rest are flawed
		// frames, short noise runs, and frames cut short and then flushed by noise,
		// which nearly always end in a failure word and leave the block hunting again.
		while (scored < RANDOM_BYTES) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				queue_frame(CONTENT_RANDOM, FLAW_NONE);
				scored += imu_rx_pkg::FRAME_LEN;
			end else if (pick < 85) begin
				queue_frame(CONTENT_RANDOM, flaw_t'($urandom_range(FLAW_HEADER_B, FLAW_SUM)));
				scored += imu_rx_pkg::FRAME_LEN;
			end else if (pick < 93) begin
				queue_noise($urandom_range(1, 6));
			end else begin
				queue_frame(CONTENT_RANDOM, FLAW_NONE);
				cut = $urandom_range(1, imu_rx_pkg::FRAME_LEN - 1);
				repeat (cut) void'(tx_q.pop_back());
				queue_noise(imu_rx_pkg::FRAME_LEN + 7);
				scored += imu_rx_pkg::FRAME_LEN;
			end
			send_queued();
		end
		push <= 1'b0;

		// The checker's count is updated, by a nonblocking write, on the edge that takes the last byte.
		@(posedge clk);
		wait (words_owed == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("imu_frame_receiver verification clean");
		else
			$display("imu_frame_receiver verification failed");
		$finish;
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("imu_frame_receiver verification failed");
			$finish;
		end
	end

endmodule
